// ----- rtl/core/acrms_pkg.sv -----
// ----------------------------------------------------------------------------
// acrms_pkg
// shared types and constants of the true-rms frame meter
// ----------------------------------------------------------------------------
package acrms_pkg;

    localparam int unsigned FRAME_RESET = 200;
    localparam int unsigned CFG_BITS    = 9;
    localparam int unsigned LEVEL_BITS  = 18;
    localparam int unsigned WIN_BITS    = 9;
    localparam int unsigned POS_BITS    = 8;

    // end-of-frame job handed from the capture side to the math engine
    typedef struct packed {
        logic          start;
        logic [12:0]   win;
        logic [11:0]   max_pos;
        logic [11:0]   min_pos;
        logic          valid;
    } t_job;

endpackage

// ----- rtl/core/ac_true_rms_frame_meter_top.sv -----
// ----------------------------------------------------------------------------
// ac_true_rms_frame_meter_top
// frame-based true-rms meter for unsigned converter samples
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall with one sample word per handshake; each
// word is written to the sample memory as it is taken, so samples within a
// frame can arrive every cycle.
// the last word of a frame starts the window engine: it walks the window
// through the memory, divides for the mean, takes the root and divides
// again; when max is not after min it stops after the mean, and an empty
// window goes straight to the output. o_stall holds off the input while
// the engine works.
// output channel: o_valid / i_stall, one result word per frame, held in an
// output register until taken; a stalled receiver holds the engine at its
// last step and then the input.
// configuration: i_cfg_we writes frame_length and restarts the frame; write
// only while the block is idle.
// reset (synchronous, i_rst_n low) clears frame position and extremes and
// sets frame_length to 200; memory contents are left as they are.
// ----------------------------------------------------------------------------
module ac_true_rms_frame_meter_top #(
    parameter int unsigned MAX_SAMPLES   = 256,
    parameter int unsigned SAMPLE_BITS   = 10,
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [acrms_pkg::CFG_BITS-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [SAMPLE_BITS-1:0]            i_sample,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [acrms_pkg::LEVEL_BITS-1:0]  o_mean_level,
    output logic [acrms_pkg::LEVEL_BITS-1:0]  o_rms_level,
    output logic [acrms_pkg::WIN_BITS-1:0]    o_window_length,
    output logic [acrms_pkg::POS_BITS-1:0]    o_max_position,
    output logic [acrms_pkg::POS_BITS-1:0]    o_min_position,
    output logic                              o_rms_valid,
    output logic                              o_empty_window
);
    import acrms_pkg::*;

    t_job                           job;
    logic [$clog2(MAX_SAMPLES)-1:0] rd_addr;
    logic [SAMPLE_BITS-1:0]         rd_data;
    logic                           busy;
    logic                           take;

    // one-cycle gap after a frame end lets the engine leave idle
    assign o_stall = busy || job.start;
    assign take    = i_valid && !o_stall;

    acrms_capture #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_capture (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_take(take), .i_sample,
        .i_rd_addr(rd_addr), .o_rd_data(rd_data), .o_job(job)
    );

    acrms_engine #(
        .MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_engine (
        .i_clk, .i_rst_n, .i_job(job), .o_rd_addr(rd_addr), .i_rd_data(rd_data),
        .o_busy(busy), .o_valid, .i_stall, .o_mean_level, .o_rms_level,
        .o_window_length, .o_max_position, .o_min_position, .o_rms_valid,
        .o_empty_window
    );
endmodule

// ----- rtl/core/acrms_div.sv -----
// ----------------------------------------------------------------------------
// acrms_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module acrms_div #(
    parameter int unsigned NUM_BITS = 72,
    parameter int unsigned DEN_BITS = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quot
);
    localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_quot;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_BITS:0]   n_rem;
    logic                n_ge;

    always_comb begin
        n_rem = {r_rem[DEN_BITS-1:0], r_quot[NUM_BITS-1]};
        n_ge  = n_rem >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quot <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CNT_BITS'(NUM_BITS);
            end else if (r_busy) begin
                r_rem  <= n_ge ? n_rem - {1'b0, r_den} : n_rem;
                r_quot <= {r_quot[NUM_BITS-2:0], n_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- rtl/core/acrms_sqrt.sv -----
// ----------------------------------------------------------------------------
// acrms_sqrt
// digit-by-digit integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module acrms_sqrt #(
    parameter int unsigned RAD_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [RAD_BITS-1:0]   i_rad,
    output logic                  o_done,
    output logic [RAD_BITS/2-1:0] o_root
);
    localparam int unsigned ROOT_BITS = RAD_BITS / 2;
    localparam int unsigned CNT_BITS  = $clog2(ROOT_BITS + 1);

    logic [RAD_BITS-1:0]  r_rad;
    logic [ROOT_BITS+1:0] r_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [ROOT_BITS+1:0] n_rem;
    logic [ROOT_BITS+1:0] n_trial;
    logic                 n_ge;

    always_comb begin
        n_rem   = {r_rem[ROOT_BITS-1:0], r_rad[RAD_BITS-1 -: 2]};
        n_trial = {r_root, 2'b01};
        n_ge    = n_rem >= n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_BITS'(ROOT_BITS);
            end else if (r_busy) begin
                r_rad  <= {r_rad[RAD_BITS-3:0], 2'b00};
                r_rem  <= n_ge ? n_rem - n_trial : n_rem;
                r_root <= {r_root[ROOT_BITS-2:0], n_ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ----- rtl/core/acrms_capture.sv -----
// ----------------------------------------------------------------------------
// acrms_capture
// frame capture into the sample memory with running extremes
// ----------------------------------------------------------------------------
module acrms_capture #(
    parameter int unsigned MAX_SAMPLES = 256,
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [acrms_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic                            i_take,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  logic [$clog2(MAX_SAMPLES)-1:0]  i_rd_addr,
    output logic [SAMPLE_BITS-1:0]          o_rd_data,
    output acrms_pkg::t_job                 o_job
);
    import acrms_pkg::*;
    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned LW = AW + 1;

    logic [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [CFG_BITS-1:0]    r_frame;
    logic [LW-1:0]          r_wpos;
    logic [SAMPLE_BITS-1:0] r_max_v, r_min_v;
    logic [AW-1:0]          r_max_p, r_min_p;
    t_job                   r_job;

    logic [LW-1:0]          n_len;
    logic [LW-1:0]          n_pos;
    logic [AW-1:0]          n_max_p, n_min_p;
    logic [SAMPLE_BITS-1:0] n_max_v, n_min_v;
    logic [AW-1:0]          n_half;
    logic [LW:0]            n_win;

    always_comb begin
        if (r_frame < CFG_BITS'(2)) n_len = LW'(2);
        else if (32'(r_frame) > MAX_SAMPLES) n_len = LW'(MAX_SAMPLES);
        else n_len = LW'(r_frame);
        n_pos = (r_wpos >= n_len) ? '0 : r_wpos;
        if (n_pos == '0) begin
            n_max_v = i_sample; n_min_v = i_sample;
            n_max_p = '0;       n_min_p = '0;
        end else begin
            n_max_v = r_max_v; n_min_v = r_min_v;
            n_max_p = r_max_p; n_min_p = r_min_p;
            if (i_sample > r_max_v) begin
                n_max_v = i_sample; n_max_p = n_pos[AW-1:0];
            end
            if (i_sample < r_min_v) begin
                n_min_v = i_sample; n_min_p = n_pos[AW-1:0];
            end
        end
        n_half = (n_max_p > n_min_p) ? n_max_p - n_min_p : n_min_p - n_max_p;
        n_win  = (LW+1)'({n_half, 1'b0});
        if (n_win > (LW+1)'(n_len)) n_win = (LW+1)'(n_len);
    end

    always_ff @(posedge i_clk) begin
        if (i_take) r_mem[n_pos[AW-1:0]] <= i_sample;
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= CFG_BITS'(FRAME_RESET);
            r_wpos  <= '0;
            r_max_v <= '0; r_min_v <= '0;
            r_max_p <= '0; r_min_p <= '0;
            r_job   <= '0;
        end else begin
            r_job.start <= 1'b0;
            if (i_cfg_we) begin
                r_frame <= i_cfg_data;
                r_wpos  <= '0;
            end else if (i_take) begin
                r_max_v <= n_max_v; r_min_v <= n_min_v;
                r_max_p <= n_max_p; r_min_p <= n_min_p;
                if (n_pos + 1'b1 >= n_len) begin
                    r_wpos        <= '0;
                    r_job.start   <= 1'b1;
                    r_job.win     <= 13'(n_win);
                    r_job.max_pos <= 12'(n_max_p);
                    r_job.min_pos <= 12'(n_min_p);
                    r_job.valid   <= n_max_p > n_min_p;
                end else begin
                    r_wpos <= n_pos + 1'b1;
                end
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_job     = r_job;
endmodule

// ----- rtl/core/acrms_engine.sv -----
// ----------------------------------------------------------------------------
// acrms_engine
// window walk over the sample memory, then mean and rms
// ----------------------------------------------------------------------------
module acrms_engine #(
    parameter int unsigned MAX_SAMPLES   = 256,
    parameter int unsigned SAMPLE_BITS   = 10,
    parameter int unsigned FRACTION_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  acrms_pkg::t_job                   i_job,
    output logic [$clog2(MAX_SAMPLES)-1:0]    o_rd_addr,
    input  logic [SAMPLE_BITS-1:0]            i_rd_data,
    output logic                              o_busy,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [acrms_pkg::LEVEL_BITS-1:0]  o_mean_level,
    output logic [acrms_pkg::LEVEL_BITS-1:0]  o_rms_level,
    output logic [acrms_pkg::WIN_BITS-1:0]    o_window_length,
    output logic [acrms_pkg::POS_BITS-1:0]    o_max_position,
    output logic [acrms_pkg::POS_BITS-1:0]    o_min_position,
    output logic                              o_rms_valid,
    output logic                              o_empty_window
);
    import acrms_pkg::*;
    localparam int unsigned AW   = $clog2(MAX_SAMPLES);
    localparam int unsigned NW   = AW + 1;
    localparam int unsigned S1W  = SAMPLE_BITS + AW;
    localparam int unsigned S2W  = 2 * SAMPLE_BITS + AW;
    localparam int unsigned DW   = S2W + NW;
    localparam int unsigned RADW = 2 * ((DW + 2 * FRACTION_BITS + 1) / 2);
    localparam int unsigned ROOTW = RADW / 2;
    localparam int unsigned QW   = (S1W + FRACTION_BITS > ROOTW)
                                   ? S1W + FRACTION_BITS : ROOTW;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_ACC, S_SQ, S_DIFF, S_MDIV, S_MWAIT,
        S_ROOT, S_RWAIT, S_RDIV, S_DWAIT, S_OUT
    } t_state;

    t_state                  r_state;
    logic [NW-1:0]           r_win;
    logic [NW-1:0]           r_idx;
    logic [AW-1:0]           r_addr;
    logic                    r_pend;
    logic                    r_dv;
    logic [2*SAMPLE_BITS-1:0] r_sq;
    logic                    r_sq_v;
    logic [S1W-1:0]          r_s1;
    logic [S2W-1:0]          r_s2;
    logic [DW-1:0]           r_p1, r_p2;
    logic [DW-1:0]           r_d;
    logic [QW-1:0]           r_mean;
    logic                    r_val;
    logic [11:0]             r_max_p, r_min_p;
    logic                    r_div_go, r_sqrt_go;
    logic [QW-1:0]           r_div_num;
    logic                    r_valid;
    logic [LEVEL_BITS-1:0]   r_o_mean, r_o_rms;
    logic [WIN_BITS-1:0]     r_o_win;
    logic [POS_BITS-1:0]     r_o_max, r_o_min;
    logic                    r_o_rv, r_o_em;

    logic                    div_done, sqrt_done;
    logic [QW-1:0]           div_q;
    logic [ROOTW-1:0]        sqrt_r;
    logic [RADW-1:0]         n_rad;

    assign n_rad = RADW'(r_d) << (2 * FRACTION_BITS);

    acrms_div #(.NUM_BITS(QW), .DEN_BITS(NW)) u_div (
        .i_clk, .i_rst_n, .i_start(r_div_go), .i_num(r_div_num), .i_den(r_win),
        .o_done(div_done), .o_quot(div_q)
    );

    acrms_sqrt #(.RAD_BITS(RADW)) u_sqrt (
        .i_clk, .i_rst_n, .i_start(r_sqrt_go), .i_rad(n_rad),
        .o_done(sqrt_done), .o_root(sqrt_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_div_go  <= 1'b0;
            r_sqrt_go <= 1'b0;
            r_pend    <= 1'b0;
            r_dv      <= 1'b0;
            r_sq_v    <= 1'b0;
        end else begin
            r_div_go  <= 1'b0;
            r_sqrt_go <= 1'b0;
            if (r_valid && !i_stall) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job.start) begin
                        r_win   <= NW'(i_job.win);
                        r_max_p <= i_job.max_pos;
                        r_min_p <= i_job.min_pos;
                        r_val   <= i_job.valid;
                        r_s1    <= '0;
                        r_s2    <= '0;
                        r_idx   <= '0;
                        r_addr  <= '0;
                        r_pend  <= 1'b0;
                        r_dv    <= 1'b0;
                        r_sq_v  <= 1'b0;
                        r_mean  <= '0;
                        r_d     <= '0;
                        r_state <= (i_job.win == '0) ? S_OUT : S_READ;
                    end
                end
                // read pipeline: address, memory read, data, square, accumulate
                S_READ: begin
                    r_pend <= 1'b0;
                    if (r_idx != r_win) begin
                        r_addr <= r_idx[AW-1:0];
                        r_idx  <= r_idx + 1'b1;
                        r_pend <= 1'b1;
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    // r_dv marks the word now on i_rd_data
                    r_dv   <= r_pend;
                    r_sq_v <= r_dv;
                    r_sq   <= i_rd_data * i_rd_data;
                    if (r_dv) r_s1 <= r_s1 + S1W'(i_rd_data);
                    if (r_sq_v) r_s2 <= r_s2 + S2W'(r_sq);
                    r_pend <= 1'b0;
                    if (r_idx != r_win) begin
                        r_addr <= r_idx[AW-1:0];
                        r_idx  <= r_idx + 1'b1;
                        r_pend <= 1'b1;
                    end else if (!r_pend && !r_dv) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_sq_v) r_s2 <= r_s2 + S2W'(r_sq);
                    r_sq_v <= 1'b0;
                    r_p1   <= DW'(r_s1) * DW'(r_s1);
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_p2    <= DW'(r_s2) * DW'(r_win);
                    r_state <= S_MDIV;
                end
                S_MDIV: begin
                    r_d       <= r_p2 - r_p1;
                    r_div_num <= QW'(r_s1) << FRACTION_BITS;
                    r_div_go  <= 1'b1;
                    r_state   <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (div_done) begin
                        r_mean  <= div_q;
                        r_state <= r_val ? S_ROOT : S_OUT;
                        if (!r_val) r_d <= '0;
                    end
                end
                S_ROOT: begin
                    r_sqrt_go <= 1'b1;
                    r_state   <= S_RWAIT;
                end
                S_RWAIT: begin
                    if (sqrt_done) begin
                        r_div_num <= QW'(sqrt_r);
                        r_div_go  <= 1'b1;
                        r_state   <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (div_done) begin
                        r_d     <= DW'(div_q);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_valid || !i_stall) begin
                        r_valid  <= 1'b1;
                        r_o_em   <= r_win == '0;
                        r_o_rv   <= r_val && (r_win != '0);
                        r_o_mean <= (r_win == '0) ? '0 : LEVEL_BITS'(r_mean);
                        r_o_rms  <= (r_win == '0 || !r_val) ? '0 : LEVEL_BITS'(r_d);
                        r_o_win  <= WIN_BITS'(r_win);
                        r_o_max  <= POS_BITS'(r_max_p);
                        r_o_min  <= POS_BITS'(r_min_p);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rd_addr       = r_addr;
    assign o_busy          = r_state != S_IDLE;
    assign o_valid         = r_valid;
    assign o_mean_level    = r_o_mean;
    assign o_rms_level     = r_o_rms;
    assign o_window_length = r_o_win;
    assign o_max_position  = r_o_max;
    assign o_min_position  = r_o_min;
    assign o_rms_valid     = r_o_rv;
    assign o_empty_window  = r_o_em;
endmodule
